[hw/rtl/mgf_pkg.sv]
// Shared types and constants for the mask gap filler.
`timescale 1ns / 1ps
package mgf_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int RWIDTH_W    = 12;
	localparam int FILL_W      = 6;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_SIZE = CFG_IDX_W'(1);

	typedef struct packed {
		logic [RWIDTH_W-1:0] row_width;
		logic [FILL_W-1:0]   fill_size;
	} cfg_t;

	typedef struct packed {
		logic pixel_set;
		logic frame_start;
	} pix_item_t;

	typedef struct packed {
		logic        run_vertical;
		logic [10:0] line_index;
		logic [10:0] run_start;
		logic [10:0] run_end;
		logic        last_result;
	} run_item_t;

	typedef struct packed {
		logic             pixel_set;
		logic             frame_start;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             h_hit;
		logic [COL_W-1:0] h_start;
		logic [COL_W-1:0] h_end;
	} job_t;

	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
	} col_entry_t;

endpackage

[hw/rtl/mgf_front.sv]
// Front end: position tracking and left-neighbor classification of each pixel.
`timescale 1ns / 1ps
module mgf_front
	import mgf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pix_valid,
	output logic      pix_stall,
	input  pix_item_t pix_data,
	output logic      job_push,
	output job_t      job_data,
	input  logic      job_full
);

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                rvalid_q;
	logic [COL_W-1:0]    rlast_q;

	logic [COL_W-1:0]    x;
	logic [ROW_W-1:0]    y;
	logic                rv;
	logic [COL_W-1:0]    rl;
	logic [COL_W-1:0]    dh;
	logic [RWIDTH_W-1:0] weff;
	logic [RWIDTH_W-1:0] x_inc;
	logic                wrap;

	assign pix_stall = job_full;
	assign job_push  = pix_valid && !job_full;

	always_comb begin
		if (pix_data.frame_start) begin
			x  = '0;
			y  = '0;
			rv = 1'b0;
			rl = '0;
		end else begin
			x  = col_q;
			y  = row_q;
			rv = rvalid_q;
			rl = rlast_q;
		end
		dh = x - rl;
		if (cfg.row_width == '0) begin
			weff = RWIDTH_W'(1);
		end else if (cfg.row_width > RWIDTH_W'(MAX_WIDTH)) begin
			weff = RWIDTH_W'(MAX_WIDTH);
		end else begin
			weff = cfg.row_width;
		end
		x_inc = RWIDTH_W'(x) + RWIDTH_W'(1);
		wrap  = x_inc >= weff;

		job_data.pixel_set   = pix_data.pixel_set;
		job_data.frame_start = pix_data.frame_start;
		job_data.col         = x;
		job_data.row         = y;
		job_data.h_hit       = pix_data.pixel_set && rv && (rl < x) &&
		                       (dh >= COL_W'(2)) && (dh <= COL_W'(cfg.fill_size));
		job_data.h_start     = rl + COL_W'(1);
		job_data.h_end       = x - COL_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rvalid_q <= 1'b0;
			rlast_q  <= '0;
		end else if (job_push) begin
			if (wrap) begin
				col_q    <= '0;
				row_q    <= (y != ROW_W'(MAX_HEIGHT - 1)) ? y + ROW_W'(1) : y;
				rvalid_q <= 1'b0;
				rlast_q  <= '0;
			end else begin
				col_q    <= x_inc[COL_W-1:0];
				row_q    <= y;
				rvalid_q <= pix_data.pixel_set ? 1'b1 : rv;
				rlast_q  <= pix_data.pixel_set ? x : rl;
			end
		end
	end

endmodule

[hw/rtl/mgf_fifo.sv]
// Short job queue between the front end and the column store engine.
`timescale 1ns / 1ps
module mgf_fifo
	import mgf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic not_empty
);

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

[hw/rtl/mgf_back.sv]
// Back end: column store clear, horizontal fill walk, vertical check, run output.
`timescale 1ns / 1ps
module mgf_back
	import mgf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	input  job_t      job_data,
	output logic      job_pop,
	output logic      run_valid,
	input  logic      run_stall,
	output run_item_t run_data
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_READ  = 6'b000100,
		ST_HFILL = 6'b001000,
		ST_HOUT  = 6'b010000,
		ST_VERT  = 6'b100000
	} back_state_t;

	back_state_t      state_q;
	job_t             job_q;
	logic [COL_W-1:0] walk_q;
	logic [COL_W-1:0] clr_q;
	col_entry_t       rd_q;
	logic             run_valid_q;
	run_item_t        run_data_q;

	col_entry_t       mem [MAX_WIDTH];

	logic             slot_free;
	logic [ROW_W-1:0] dv;
	logic             v_hit;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	col_entry_t       wr_data;
	logic             rd_en;
	logic             emit_h;
	logic             emit_v;
	run_item_t        h_item;
	run_item_t        v_item;

	assign run_valid = run_valid_q;
	assign run_data  = run_data_q;
	assign job_pop   = (state_q == ST_IDLE) && job_valid;

	always_comb begin
		slot_free = !run_valid_q || !run_stall;
		dv        = job_q.row - rd_q.row;
		v_hit     = rd_q.valid && (rd_q.row < job_q.row) &&
		            (dv >= ROW_W'(2)) && (dv <= ROW_W'(cfg.fill_size));
		rd_en     = state_q == ST_READ;
		emit_h    = (state_q == ST_HOUT) && slot_free;
		emit_v    = (state_q == ST_VERT) && v_hit && slot_free;

		h_item.run_vertical = 1'b0;
		h_item.line_index   = 11'(job_q.row);
		h_item.run_start    = 11'(job_q.h_start);
		h_item.run_end      = 11'(job_q.h_end);
		h_item.last_result  = !v_hit;

		v_item.run_vertical = 1'b1;
		v_item.line_index   = 11'(job_q.col);
		v_item.run_start    = 11'(rd_q.row + ROW_W'(1));
		v_item.run_end      = 11'(job_q.row - ROW_W'(1));
		v_item.last_result  = 1'b1;

		wr_en         = 1'b0;
		wr_addr       = job_q.col;
		wr_data.valid = 1'b1;
		wr_data.row   = job_q.row;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_HFILL: begin
				wr_en   = 1'b1;
				wr_addr = walk_q;
			end
			ST_VERT: begin
				wr_en = !v_hit || slot_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[job_q.col];
		end
		if (emit_h) begin
			run_data_q <= h_item;
		end else if (emit_v) begin
			run_data_q <= v_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			job_q       <= '0;
			walk_q      <= '0;
			clr_q       <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (emit_h || emit_v) begin
				run_valid_q <= 1'b1;
			end else if (!run_stall) begin
				run_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job_data;
						if (job_data.frame_start) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (job_data.pixel_set) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + COL_W'(1);
					if (clr_q == COL_W'(MAX_WIDTH - 1)) begin
						state_q <= job_q.pixel_set ? ST_READ : ST_IDLE;
					end
				end
				ST_READ: begin
					if (job_q.h_hit) begin
						walk_q  <= job_q.h_start;
						state_q <= ST_HFILL;
					end else begin
						state_q <= ST_VERT;
					end
				end
				ST_HFILL: begin
					walk_q <= walk_q + COL_W'(1);
					if (walk_q == job_q.h_end) begin
						state_q <= ST_HOUT;
					end
				end
				ST_HOUT: begin
					if (slot_free) begin
						state_q <= ST_VERT;
					end
				end
				ST_VERT: begin
					if (!v_hit || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/mask_gap_fill_left_up.sv]
// Top level of the mask gap filler: configuration registers and unit wiring.
//
//   channel   handshake           beat
//   pix       pix_valid/stall     pix_data  (pixel_set, frame_start)
//   run       run_valid/stall     run_data  (one fill run)
//   cfg       cfg_valid/ready     cfg_index, cfg_data
//
// The front end takes one pixel per cycle into a 4-deep job queue unless it is full.
// The column store engine takes a clear pixel straight from idle. A set pixel is
// read and checked for a vertical run; a horizontal run adds a gap walk and output.
// Reset and every frame_start beat run a pass that clears the whole column
// store; pixels still fill the queue during it.
// A stalled run output holds the engine; the queue then fills and raises pix_stall.
`timescale 1ns / 1ps
module mask_gap_fill_left_up
	import mgf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_item_t             pix_data,
	output logic                  run_valid,
	input  logic                  run_stall,
	output run_item_t             run_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic job_push;
	job_t job_in;
	logic job_full;
	logic job_pop;
	job_t job_out;
	logic job_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width <= RWIDTH_W'(MAX_WIDTH);
			cfg_q.fill_size <= FILL_W'(8);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROW_WIDTH: cfg_q.row_width <= cfg_data[RWIDTH_W-1:0];
				CFG_FILL_SIZE: cfg_q.fill_size <= cfg_data[FILL_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mgf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.job_push  (job_push),
		.job_data  (job_in),
		.job_full  (job_full)
	);

	mgf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.not_empty (job_valid)
	);

	mgf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job_data  (job_out),
		.job_pop   (job_pop),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.run_data  (run_data)
	);

endmodule

[tb/tb_mask_gap_fill_left_up.sv]
// Self-checking testbench for the mask gap filler, with directed and random pixel streams.
`timescale 1ns / 1ps
module tb_mask_gap_fill_left_up;
	import mgf_pkg::*;

	localparam int FILL_LIMIT   = 63;
	localparam int SETTLE_TICKS = 12000;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(15);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_item_t             pix_data  = '0;
	logic                  run_valid;
	logic                  run_stall = 1'b0;
	run_item_t             run_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [ROW_W-1:0]    col_row [MAX_WIDTH];
	bit                  col_ok  [MAX_WIDTH];
	int                  cur_col  = 0;
	int                  cur_row  = 0;
	int                  row_last = 0;
	bit                  row_ok   = 1'b0;
	logic [RWIDTH_W-1:0] width_shadow = RWIDTH_W'(2048);
	logic [FILL_W-1:0]   fill_shadow  = FILL_W'(8);

	run_item_t fill_runs [$];
	pix_item_t pix_pending [$];
	int        pix_sent   = 0;
	int        pix_taken  = 0;
	int        pix_gap    = 0;
	int        stall_gap  = 0;
	int        mismatches = 0;
	bit        idle_on    = 1'b1;

	mask_gap_fill_left_up u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.run_data  (run_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	function automatic void predict_runs(pix_item_t px);
		int        w;
		int        fs;
		int        x;
		int        y;
		int        d;
		int        n;
		int        c;
		run_item_t r [2];
		w = int'(width_shadow);
		if (w == 0) begin
			w = 1;
		end
		if (w > MAX_WIDTH) begin
			w = MAX_WIDTH;
		end
		fs = int'(fill_shadow);
		if (fs > FILL_LIMIT) begin
			fs = FILL_LIMIT;
		end
		n = 0;
		if (px.frame_start) begin
			foreach (col_ok[i]) col_ok[i] = 1'b0;
			cur_col  = 0;
			cur_row  = 0;
			row_last = 0;
			row_ok   = 1'b0;
		end
		x = cur_col % MAX_WIDTH;
		y = cur_row;
		if (px.pixel_set) begin
			if (row_ok && row_last < x) begin
				d = x - row_last;
				if (d >= 2 && d <= fs) begin
					for (c = row_last + 1; c < x; c++) begin
						col_row[c] = ROW_W'(y);
						col_ok[c]  = 1'b1;
					end
					r[n] = {1'b0, 11'(y), 11'(row_last + 1), 11'(x - 1), 1'b0};
					n++;
				end
			end
			if (col_ok[x] && int'(col_row[x]) < y) begin
				d = y - int'(col_row[x]);
				if (d >= 2 && d <= fs) begin
					r[n] = {1'b1, 11'(x), 11'(int'(col_row[x]) + 1), 11'(y - 1), 1'b0};
					n++;
				end
			end
			row_last  = x;
			row_ok    = 1'b1;
			col_row[x] = ROW_W'(y);
			col_ok[x]  = 1'b1;
		end
		if (n > 0) begin
			r[n - 1].last_result = 1'b1;
		end
		for (c = 0; c < n; c++) begin
			fill_runs.insert(fill_runs.size(), r[c]);
		end
		if (x + 1 >= w) begin
			cur_col = 0;
			if (cur_row < MAX_HEIGHT - 1) begin
				cur_row++;
			end
			row_ok   = 1'b0;
			row_last = 0;
		end else begin
			cur_col = x + 1;
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_taken == pix_sent)) begin
			if (pix_gap > 0) begin
				pix_gap--;
				pix_valid <= 1'b0;
			end else if (pix_pending.size() > 0) begin
				pix_data  <= pix_pending.pop_front();
				pix_valid <= 1'b1;
				pix_sent++;
				if (idle_on && $urandom_range(0, 7) == 0) begin
					pix_gap = $urandom_range(1, 12);
				end
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_gap > 0) begin
				stall_gap--;
				run_stall <= 1'b1;
			end else begin
				run_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 7) == 0) begin
					stall_gap = $urandom_range(1, 12);
				end
			end
		end
	end

	always @(posedge clk) begin : run_monitor
		run_item_t want;
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				predict_runs(pix_data);
				pix_taken++;
			end
			if (run_valid && !run_stall) begin
				if (fill_runs.size() == 0) begin
					report_mismatch($sformatf("unexpected run beat %h", run_data));
				end else begin
					want = fill_runs.pop_front();
					check_field("run_vertical", run_data.run_vertical, want.run_vertical);
					check_field("line_index", run_data.line_index, want.line_index);
					check_field("run_start", run_data.run_start, want.run_start);
					check_field("run_end", run_data.run_end, want.run_end);
					check_field("last_result", run_data.last_result, want.last_result);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_ROW_WIDTH) begin
			width_shadow = val;
		end else if (idx == CFG_FILL_SIZE) begin
			fill_shadow = val[FILL_W-1:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pattern codes: 0 clear, 1 set, S set with frame start, s clear with frame start.
	task automatic run_phase(int width, int fill, int count, int set_pct, int frame_pct,
			bit new_frame, string pat);
		logic [CFG_DATA_W-1:0] fill_word;
		bit                    start;
		pix_item_t             item;
		fill_word = CFG_DATA_W'($urandom);
		fill_word[FILL_W-1:0] = FILL_W'(fill);
		write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width));
		write_reg(CFG_FILL_SIZE, fill_word);
		if (pat.len() > 0) begin
			foreach (pat[i]) begin
				item.pixel_set   = pat[i] == "1" || pat[i] == "S";
				item.frame_start = pat[i] == "S" || pat[i] == "s";
				pix_pending.insert(pix_pending.size(), item);
			end
		end else begin
			for (int i = 0; i < count; i++) begin
				start = (new_frame && i == 0) || ($urandom_range(0, 99) < frame_pct);
				item.pixel_set   = $urandom_range(0, 99) < set_pct;
				item.frame_start = start;
				pix_pending.insert(pix_pending.size(), item);
			end
		end
		while (pix_pending.size() != 0 || pix_sent != pix_taken || fill_runs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_phase(5, 8, 0, 0, 0, 1'b0, "S00100000001011000s1001");
		write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
		run_phase(5, 1, 0, 0, 0, 1'b0, "101");
		run_phase(5, 0, 0, 0, 0, 1'b0, "101");

		run_phase(0, 63, 40, 30, 2, 1'b0, "");
		run_phase(16, 5, 40, 50, 2, 1'b0, "");
		run_phase(7, 63, 40, 25, 2, 1'b0, "");
		run_phase(4095, 63, 40, 10, 0, 1'b0, "");
		run_phase(3, 2, 40, 50, 2, 1'b0, "");
		run_phase(2048, 63, 40, 6, 0, 1'b1, "");
		run_phase(1, 63, 40, 12, 0, 1'b1, "");
		for (int p = 0; p < 5; p++) begin
			if (p >= 3) begin
				idle_on = 1'b0;
			end
			run_phase($urandom_range(1, 40), $urandom_range(0, 63), 20,
				$urandom_range(10, 70), 2, 1'b0, "");
		end

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#36_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
hw/rtl/mgf_pkg.sv
hw/rtl/mgf_front.sv
hw/rtl/mgf_fifo.sv
hw/rtl/mgf_back.sv
hw/rtl/mask_gap_fill_left_up.sv
tb/tb_mask_gap_fill_left_up.sv
